// ===== hdl/radix_integer_to_ascii_macros.svh =====
// Assertion macros for the radix integer-to-ASCII converter.
`ifndef RADIX_INTEGER_TO_ASCII_MACROS_SVH
`define RADIX_INTEGER_TO_ASCII_MACROS_SVH
`ifndef SYNTHESIS
`define RI2A_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("radix_integer_to_ascii: same-cycle check failed");
`define RI2A_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("radix_integer_to_ascii: next-cycle check failed");
`else
`define RI2A_ASSERT_NOW(label, clk, rst, ante, cons)
`define RI2A_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/ri2a_pkg.sv =====
// Shared constants and helper functions for the radix integer-to-ASCII converter.
package ri2a_pkg;

   localparam int VALUE_WIDTH_DEF = 32;
   localparam int DIGIT_CAP_DEF   = 32;
   localparam int RADIX_W         = 6;
   localparam int CHAR_W          = 7;

   localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
   localparam logic [RADIX_W-1:0] DIGIT_TOP   = 6'd35;
   localparam logic [RADIX_W-1:0] DIGIT_TEN   = 6'd10;
   localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'h30;  // '0'
   localparam logic [CHAR_W-1:0]  CHAR_LETTER = 7'h37;  // 'A' - 10

   function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
      logic [RADIX_W-1:0] c;
      c = r;
      if (r < RADIX_MIN) c = RADIX_MIN;
      else if (r > RADIX_MAX) c = RADIX_MAX;
      return c;
   endfunction

   function automatic logic [CHAR_W-1:0] digit_to_char(input logic [RADIX_W-1:0] d);
      logic [RADIX_W-1:0] s;
      logic [CHAR_W-1:0]  c;
      s = (d > DIGIT_TOP) ? DIGIT_TOP : d;
      if (s < DIGIT_TEN) c = CHAR_ZERO + {1'b0, s};
      else c = CHAR_LETTER + {1'b0, s};
      return c;
   endfunction

endpackage

// ===== hdl/radix_integer_to_ascii.sv =====
// Top level of the radix integer-to-ASCII converter.
//
//   channel  ports                                          direction
//   req      req_valid/req_ready, req_value, req_radix      in
//   rsp      rsp_valid/rsp_ready, rsp_digit_char, rsp_last  out
//
// One word in at a time. Each digit comes from the bit-serial divider, and each
// output digit passes a store read, then a show state; a zero value skips the
// divider and stores a single '0' digit. Synchronous active-high reset returns
// to idle. Stalls on rsp hold the current word; req_ready is high only while idle.
`include "radix_integer_to_ascii_macros.svh"

module radix_integer_to_ascii
   import ri2a_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
   parameter int DIGIT_CAP   = DIGIT_CAP_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [VALUE_WIDTH-1:0] req_value,
   input  logic [RADIX_W-1:0]     req_radix,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [CHAR_W-1:0]      rsp_digit_char,
   output logic                   rsp_last
);

   localparam int ADDR_W = $clog2(DIGIT_CAP);
   localparam int CNT_W  = $clog2(DIGIT_CAP + 1);
   localparam logic [CNT_W-1:0] CAP_CNT = DIGIT_CAP[CNT_W-1:0];

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_RD   = 2'd2;
   localparam logic [1:0] ST_SHOW = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [ADDR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [RADIX_W-1:0] radix_ff, radix_in;

   logic                   req_fire;
   logic                   value_zero;
   logic                   div_start;
   logic [VALUE_WIDTH-1:0] div_dividend;
   logic                   div_done;
   logic [VALUE_WIDTH-1:0] div_quo;
   logic [RADIX_W-1:0]     div_rem;
   logic [CNT_W-1:0]       count_next;

   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [RADIX_W-1:0] wr_data;
   logic               rd_en;
   logic [RADIX_W-1:0] rd_data;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign value_zero = (req_value == '0);
   assign count_next = count_ff + 1'b1;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rd_ptr_in    = rd_ptr_ff;
      radix_in     = radix_ff;
      div_start    = 1'b0;
      div_dividend = div_quo;
      wr_en        = 1'b0;
      wr_addr      = count_ff[ADDR_W-1:0];
      wr_data      = div_rem;
      rd_en        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               radix_in = clamp_radix(req_radix);
               if (value_zero) begin
                  // zero still stores one '0' digit
                  wr_en     = 1'b1;
                  wr_addr   = '0;
                  wr_data   = '0;
                  count_in  = {{(CNT_W-1){1'b0}}, 1'b1};
                  rd_ptr_in = '0;
                  state_in  = ST_RD;
               end else begin
                  div_start    = 1'b1;
                  div_dividend = req_value;
                  count_in     = '0;
                  state_in     = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               wr_en    = 1'b1;
               count_in = count_next;
               if ((div_quo == '0) || (count_next == CAP_CNT)) begin
                  rd_ptr_in = count_ff[ADDR_W-1:0];
                  state_in  = ST_RD;
               end else begin
                  div_start = 1'b1;
               end
            end
         end
         ST_RD: begin
            rd_en    = 1'b1;
            state_in = ST_SHOW;
         end
         ST_SHOW: begin
            if (rsp_ready) begin
               if (rd_ptr_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_ptr_in = rd_ptr_ff - 1'b1;
                  state_in  = ST_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      rd_ptr_ff <= rd_ptr_in;
      radix_ff  <= radix_in;
   end

   ri2a_div #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .radix    (radix_ff),
      .done     (div_done),
      .quotient (div_quo),
      .remainder(div_rem)
   );

   ri2a_ram #(
      .WIDTH(RADIX_W),
      .DEPTH(DIGIT_CAP)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_ptr_ff),
      .rd_data(rd_data)
   );

   assign rsp_valid      = (state_ff == ST_SHOW);
   assign rsp_digit_char = digit_to_char(rd_data);
   assign rsp_last       = (rd_ptr_ff == '0);

   `RI2A_ASSERT_NOW(a_done_in_div, clock, reset, div_done, state_ff == ST_DIV)
   `RI2A_ASSERT_NOW(a_count_below_cap, clock, reset, state_ff == ST_DIV, count_ff < CAP_CNT)
   `RI2A_ASSERT_NEXT(a_last_returns_idle, clock, reset, rsp_valid && rsp_ready && rsp_last, req_ready)
   `RI2A_ASSERT_NEXT(a_accept_starts_work, clock, reset, req_fire, !req_ready)

endmodule

// ===== hdl/ri2a_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ri2a_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/ri2a_div.sv =====
// Bit-serial restoring divider: dividend by a small radix, one quotient bit per cycle.
module ri2a_div
   import ri2a_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [VALUE_WIDTH-1:0] dividend,
   input  logic [RADIX_W-1:0]     radix,
   output logic                   done,
   output logic [VALUE_WIDTH-1:0] quotient,
   output logic [RADIX_W-1:0]     remainder
);

   localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

   logic [VALUE_WIDTH-1:0] quo_ff, quo_in;
   logic [RADIX_W-1:0]     rem_ff, rem_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   done_ff, done_in;
   logic [RADIX_W:0]       trial;
   logic [RADIX_W:0]       diff;
   logic                   fits;

   // partial remainder stays below radix, so the shifted trial fits in one extra bit
   assign trial = {rem_ff, quo_ff[VALUE_WIDTH-1]};
   assign diff  = trial - {1'b0, radix};
   assign fits  = (trial >= {1'b0, radix});

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         cnt_in = VALUE_WIDTH[CNT_W-1:0];
      end else if (cnt_ff != '0) begin
         quo_in  = {quo_ff[VALUE_WIDTH-2:0], fits};
         rem_in  = fits ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == {{(CNT_W-1){1'b0}}, 1'b1});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== test/radix_integer_to_ascii_checker.sv =====
// Digit-stream predictor and response checker for the radix integer-to-ASCII converter.
`timescale 1ns / 1ps

module radix_integer_to_ascii_checker
   import ri2a_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [VALUE_WIDTH_DEF-1:0] req_value,
   input  logic [RADIX_W-1:0]         req_radix,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [CHAR_W-1:0]          rsp_digit_char,
   input  logic                       rsp_last,
   output int                         mismatches,
   output int                         pending
);

   typedef struct packed {
      logic [CHAR_W-1:0] digit_char;
      logic              last;
   } digit_word_type;

   localparam logic [7:0] ASCII_0 = "0";
   localparam logic [7:0] ASCII_A = "A";
   localparam int         PRINT_CAP = 100;

   digit_word_type expected_chars[$];

   task automatic report_mismatch(input string what);
      if (mismatches < PRINT_CAP)
         $display("%0t ns: mismatch: %s", $realtime, what);
      mismatches++;
   endtask

   // Divide down to digits, least significant first, then queue them back to front.
   function automatic void predict_digits(input logic [VALUE_WIDTH_DEF-1:0] value,
                                          input logic [RADIX_W-1:0] radix_in);
      logic [VALUE_WIDTH_DEF-1:0] quotient;
      logic [RADIX_W-1:0]         digits[DIGIT_CAP_DEF];
      logic [7:0]                 ascii;
      logic [RADIX_W-1:0]         base;
      int                         count;
      digit_word_type             w;
      if (radix_in < RADIX_MIN) base = RADIX_MIN;
      else if (radix_in > RADIX_MAX) base = RADIX_MAX;
      else base = radix_in;
      quotient = value;
      count    = 0;
      if (quotient == 0) begin
         digits[0] = '0;
         count     = 1;
      end else begin
         while (quotient != 0 && count < DIGIT_CAP_DEF) begin
            digits[count] = RADIX_W'(quotient % base);
            quotient      = quotient / base;
            count++;
         end
      end
      for (int k = count - 1; k >= 0; k--) begin
         if (digits[k] < 10) ascii = ASCII_0 + digits[k];
         else ascii = ASCII_A + (digits[k] - 8'd10);
         w.digit_char = ascii[CHAR_W-1:0];
         w.last       = (k == 0);
         expected_chars.push_back(w);
      end
   endfunction

   always @(posedge clock) begin : watch
      digit_word_type want;
      if (reset) begin
         mismatches = 0;
      end else begin
         if (req_valid && req_ready)
            predict_digits(req_value, req_radix);
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               report_mismatch($sformatf("unexpected word char=0x%02h last=%0b",
                                         rsp_digit_char, rsp_last));
            end else begin
               want = expected_chars.pop_front();
               if (rsp_digit_char !== want.digit_char)
                  report_mismatch($sformatf("digit_char got 0x%02h want 0x%02h",
                                            rsp_digit_char, want.digit_char));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("last got %0b want %0b (char 0x%02h)",
                                            rsp_last, want.last, want.digit_char));
            end
         end
      end
      pending <= expected_chars.size();
   end

endmodule

// ===== test/tb_radix_integer_to_ascii.sv =====
// Top-level testbench for the radix integer-to-ASCII converter: stimulus and verdict.
`timescale 1ns / 1ps

module tb_radix_integer_to_ascii;
   import ri2a_pkg::*;

   localparam int RANDOM_WORDS = 80;
   localparam int HOLD_CYCLES  = 1500;
   localparam int DRAIN_CYCLES = 50;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [VALUE_WIDTH_DEF-1:0] req_value = '0;
   logic [RADIX_W-1:0]         req_radix = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [CHAR_W-1:0]          rsp_digit_char;
   logic                       rsp_last;

   int mismatches;
   int pending;
   bit idling_on = 1'b1;
   bit hold_request = 1'b0;

   always #2 clock = ~clock;

   radix_integer_to_ascii dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_value      (req_value),
      .req_radix      (req_radix),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last)
   );

   radix_integer_to_ascii_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_value      (req_value),
      .req_radix      (req_radix),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last),
      .mismatches     (mismatches),
      .pending        (pending)
   );

   // Offer one word and return at the edge that accepts it.
   task automatic send_word(input logic [VALUE_WIDTH_DEF-1:0] v, input logic [RADIX_W-1:0] r);
      if (idling_on && $urandom_range(0, 99) < 33) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      req_radix <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Receiver: random back-pressure, plus one long hold-off on request.
   initial begin : receiver
      bit hold_done;
      hold_done = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= !(idling_on && $urandom_range(0, 99) < 33);
      end
   end

   initial begin : stimulus
      logic [VALUE_WIDTH_DEF-1:0] v;
      logic [RADIX_W-1:0]         r;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero value, with and without radix clamping
      send_word(32'd0, 6'd10);
      send_word(32'd0, 6'd0);
      send_word(32'd0, 6'd63);
      // longest run: 32 binary digits
      send_word(32'hFFFF_FFFF, 6'd2);
      send_word(32'hFFFF_FFFF, 6'd36);
      send_word(32'hFFFF_FFFF, 6'd63);
      send_word(32'hFFFF_FFFF, 6'd16);
      send_word(32'hFFFF_FFFF, 6'd10);
      send_word(32'h8000_0000, 6'd2);
      send_word(32'h7FFF_FFFF, 6'd3);
      send_word(32'd1, 6'd1);
      send_word(32'd1, 6'd2);
      send_word(32'd35, 6'd36);
      send_word(32'd36, 6'd36);
      send_word(32'd63, 6'd37);
      send_word(32'd9, 6'd10);
      send_word(32'd10, 6'd10);
      send_word(32'd255, 6'd16);
      send_word(32'd1234567890, 6'd10);
      send_word(32'hDEAD_BEEF, 6'd8);
      send_word(32'h5555_5555, 6'd35);

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i == 20) hold_request = 1'b1;
         idling_on = !(i >= 45 && i < 75);
         case ($urandom_range(0, 3))
            0: v = $urandom_range(0, 40);
            1: v = $urandom >> $urandom_range(0, 31);
            default: v = $urandom;
         endcase
         if ($urandom_range(0, 3) == 0) r = RADIX_W'($urandom_range(0, 63));
         else r = RADIX_W'($urandom_range(2, 36));
         send_word(v, r);
      end
      req_valid <= 1'b0;
      idling_on = 1'b1;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("[radix_integer_to_ascii] OK");
      end else begin
         $display("[radix_integer_to_ascii] ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #3_000_000;
      $display("[radix_integer_to_ascii] ERROR");
      $finish;
   end

endmodule
